// ----- hdl/contiguous_page_allocator_macros.svh -----
// ----------------------------------------------------------------------------
// contiguous_page_allocator_macros
// Assertion helpers shared by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef CONTIGUOUS_PAGE_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_PAGE_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define CPA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CPA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/cpa_pkg.sv -----
// ----------------------------------------------------------------------------
// cpa_pkg
// Types and constants of the contiguous page allocator.
// ----------------------------------------------------------------------------
package cpa_pkg;

  localparam int MAX_PAGES      = 1024;
  localparam int PAGE_SHIFT     = 12;
  localparam int RESERVED_PAGES = 8;
  localparam int IDX_W          = $clog2(MAX_PAGES);
  localparam int CNT_W          = $clog2(MAX_PAGES + 1);
  localparam int ADDR_W         = 32;
  localparam int AMT_W          = 32;
  localparam int TOT_W          = ADDR_W - PAGE_SHIFT;
  localparam int CFG_IDX_W      = 1;
  localparam int IN_DATA_W      = 64;
  localparam int IN_USER_W      = 2;
  localparam int OUT_DATA_W     = 40;
  localparam int STATUS_W       = 2;

  localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'((1 << PAGE_SHIFT) - 1);
  localparam logic [ADDR_W-1:0] BASE_BIAS =
    ADDR_W'((RESERVED_PAGES << PAGE_SHIFT) + (1 << PAGE_SHIFT) - 1);

  localparam int FLAG_TAKEN_BIT = 0;
  localparam int FLAG_LAST_BIT  = 1;
  localparam logic [1:0] FLAG_FREE       = 2'b00;
  localparam logic [1:0] FLAG_TAKEN      = 2'b01;
  localparam logic [1:0] FLAG_TAKEN_LAST = 2'b11;

  localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_LEN  = 1'd1;

  typedef enum logic [1:0] {
    OP_ALLOC_PAGES = 2'd0,
    OP_ALLOC_BYTES = 2'd1,
    OP_FREE        = 2'd2,
    OP_CLEAR       = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_FAIL    = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  typedef struct packed {
    logic [CNT_W-1:0]  pages;
    logic [ADDR_W-1:0] base;
  } geom_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [1:0]       wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    status_t           status;
  } result_t;

endpackage

// ----- hdl/cpa_geom.sv -----
// ----------------------------------------------------------------------------
// cpa_geom
// Heap registers and derived geometry: usable page count and base address.
// ----------------------------------------------------------------------------
module cpa_geom (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cpa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cpa_pkg::ADDR_W-1:0]      cfg_wdata,
  output cpa_pkg::geom_t                  geom
);
  import cpa_pkg::*;

  logic [ADDR_W-1:0] region_base_r;
  logic [ADDR_W-1:0] region_len_r;
  logic [TOT_W-1:0]  total;
  logic [TOT_W-1:0]  total_adj;
  logic [ADDR_W-1:0] base_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_base_r <= '0;
      region_len_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REGION_BASE: region_base_r <= cfg_wdata;
        REG_REGION_LEN:  region_len_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    total     = region_len_r[ADDR_W-1:PAGE_SHIFT];
    total_adj = total - TOT_W'(RESERVED_PAGES);
    if (total < TOT_W'(RESERVED_PAGES)) begin
      geom.pages = '0;
    end else if (ADDR_W'(total_adj) > ADDR_W'(MAX_PAGES)) begin
      geom.pages = CNT_W'(MAX_PAGES);
    end else begin
      geom.pages = CNT_W'(total_adj);
    end
    base_sum  = region_base_r + BASE_BIAS;
    geom.base = base_sum & ~PAGE_MASK;
  end

endmodule

// ----- hdl/cpa_flag_store.sv -----
// ----------------------------------------------------------------------------
// cpa_flag_store
// Per-page taken/last flags, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cpa_flag_store (
  input  logic              clk,
  input  cpa_pkg::mem_req_t req,
  output logic [1:0]        rd_data
);
  import cpa_pkg::*;

  logic [1:0] flags_mem [MAX_PAGES];
  logic [1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      flags_mem[req.waddr] <= req.wdata;
    end
    rd_data_r <= flags_mem[req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/cpa_seq.sv -----
// ----------------------------------------------------------------------------
// cpa_seq
// Sequencer: table sweep, first-fit scan, run marking and release walk,
// all sharing one page pointer and compare unit.
// ----------------------------------------------------------------------------
module cpa_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  cpa_pkg::op_t                in_op,
  input  logic [cpa_pkg::AMT_W-1:0]   in_amount,
  input  logic [cpa_pkg::ADDR_W-1:0]  in_addr,
  input  cpa_pkg::geom_t              geom,
  output cpa_pkg::mem_req_t           mem_req,
  input  logic [1:0]                  rd_data,
  output cpa_pkg::result_t            res,
  input  logic                        res_take
);
  import cpa_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_MARK  = 6'b001000,
    S_FREE  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t           state_r,  state_nxt;
  logic [CNT_W-1:0] ptr_r,    ptr_nxt;
  logic [CNT_W-1:0] ev_r,     ev_nxt;
  logic             pv_r,     pv_nxt;
  logic [CNT_W-1:0] run_r,    run_nxt;
  logic [CNT_W-1:0] req_r,    req_nxt;
  logic [IDX_W-1:0] first_r,  first_nxt;
  logic [IDX_W-1:0] end_r,    end_nxt;
  logic             grant_r,  grant_nxt;
  logic             clr_op_r, clr_op_nxt;
  status_t          status_r, status_nxt;

  logic [AMT_W:0]    byte_sum;
  logic [AMT_W-1:0]  req_pg;
  logic              req_bad;
  logic [ADDR_W-1:0] rel_off;
  logic [TOT_W-1:0]  rel_idx;
  logic              rel_bad;
  logic [CNT_W-1:0]  run_inc;

  always_comb begin
    byte_sum = {1'b0, in_amount} + (AMT_W+1)'(PAGE_MASK);
    if (in_op == OP_ALLOC_BYTES) begin
      req_pg = AMT_W'(byte_sum >> PAGE_SHIFT);
    end else begin
      req_pg = in_amount;
    end
    req_bad = (req_pg == '0) || (req_pg > AMT_W'(geom.pages));
    rel_off = in_addr - geom.base;
    rel_idx = rel_off[ADDR_W-1:PAGE_SHIFT];
    rel_bad = (in_addr == '0) || (in_addr < geom.base) ||
              (ADDR_W'(rel_idx) >= ADDR_W'(geom.pages));
  end

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    ev_nxt        = ev_r;
    pv_nxt        = pv_r;
    run_nxt       = run_r;
    req_nxt       = req_r;
    first_nxt     = first_r;
    end_nxt       = end_r;
    grant_nxt     = grant_r;
    clr_op_nxt    = clr_op_r;
    status_nxt    = status_r;
    in_ready      = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = ptr_r[IDX_W-1:0];
    mem_req.wdata = FLAG_FREE;
    mem_req.raddr = ptr_r[IDX_W-1:0];
    run_inc       = run_r + CNT_W'(1);
    res.valid     = 1'b0;
    res.status    = status_r;
    res.addr      = grant_r ?
                    geom.base + ADDR_W'({first_r, {PAGE_SHIFT{1'b0}}}) : '0;

    case (state_r)
      S_CLEAR: begin
        mem_req.we = 1'b1;
        ptr_nxt    = ptr_r + CNT_W'(1);
        if (ptr_r == CNT_W'(MAX_PAGES - 1)) begin
          state_nxt  = clr_op_r ? S_DONE : S_IDLE;
          clr_op_nxt = 1'b0;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          grant_nxt = 1'b0;
          pv_nxt    = 1'b0;
          case (in_op)
            OP_ALLOC_PAGES, OP_ALLOC_BYTES: begin
              status_nxt = ST_FAIL;
              if (req_bad) begin
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_SCAN;
                ptr_nxt   = '0;
                run_nxt   = '0;
                req_nxt   = CNT_W'(req_pg);
              end
            end
            OP_FREE: begin
              if (rel_bad) begin
                status_nxt = ST_IGNORED;
                state_nxt  = S_DONE;
              end else begin
                status_nxt = ST_DONE;
                ptr_nxt    = CNT_W'(rel_idx);
                state_nxt  = S_FREE;
              end
            end
            OP_CLEAR: begin
              status_nxt = ST_DONE;
              ptr_nxt    = '0;
              clr_op_nxt = 1'b1;
              state_nxt  = S_CLEAR;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        ptr_nxt = ptr_r + CNT_W'(1);
        ev_nxt  = ptr_r;
        pv_nxt  = 1'b1;
        if (pv_r) begin
          if (rd_data[FLAG_TAKEN_BIT]) begin
            run_nxt = '0;
          end else begin
            run_nxt = run_inc;
          end
          if (!rd_data[FLAG_TAKEN_BIT] && run_inc == req_r) begin
            first_nxt  = IDX_W'(ev_r + CNT_W'(1) - req_r);
            end_nxt    = ev_r[IDX_W-1:0];
            ptr_nxt    = CNT_W'(ev_r + CNT_W'(1) - req_r);
            grant_nxt  = 1'b1;
            status_nxt = ST_DONE;
            state_nxt  = S_MARK;
          end else if (ev_r == geom.pages - CNT_W'(1)) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_MARK: begin
        mem_req.we = 1'b1;
        ptr_nxt    = ptr_r + CNT_W'(1);
        if (ptr_r[IDX_W-1:0] == end_r) begin
          mem_req.wdata = FLAG_TAKEN_LAST;
          state_nxt     = S_DONE;
        end else begin
          mem_req.wdata = FLAG_TAKEN;
        end
      end
      S_FREE: begin
        ptr_nxt = ptr_r + CNT_W'(1);
        ev_nxt  = ptr_r;
        pv_nxt  = 1'b1;
        if (pv_r) begin
          if (ev_r == geom.pages || !rd_data[FLAG_TAKEN_BIT]) begin
            state_nxt = S_DONE;
          end else begin
            mem_req.we    = 1'b1;
            mem_req.waddr = ev_r[IDX_W-1:0];
            if (rd_data[FLAG_LAST_BIT]) begin
              state_nxt = S_DONE;
            end
          end
        end
      end
      S_DONE: begin
        res.valid = 1'b1;
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      ptr_r    <= '0;
      pv_r     <= 1'b0;
      clr_op_r <= 1'b0;
      grant_r  <= 1'b0;
      status_r <= ST_DONE;
    end else begin
      state_r  <= state_nxt;
      ptr_r    <= ptr_nxt;
      pv_r     <= pv_nxt;
      clr_op_r <= clr_op_nxt;
      grant_r  <= grant_nxt;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_r    <= ev_nxt;
    run_r   <= run_nxt;
    req_r   <= req_nxt;
    first_r <= first_nxt;
    end_r   <= end_nxt;
  end

endmodule

// ----- hdl/contiguous_page_allocator.sv -----
// ----------------------------------------------------------------------------
// contiguous_page_allocator
// First-fit allocator of contiguous heap pages with a per-page flag table.
// ----------------------------------------------------------------------------
// Usage: set the region base (index 0) and region size (index 1) on the cfg
// port while idle. Each in_ transaction carries an operation in in_tuser and
// the amount/address in in_tdata; exactly one out_ transaction returns the
// granted address and status.
// Allocation scans the flag table first-fit and then marks the run; free
// walks the run from its first page; clear all sweeps all MAX_PAGES entries;
// a rejected request or an ignored free goes straight to the result. The
// flag table has one read and one write port, so the scan and the release
// walk advance one page per cycle.
// in_tready is high only while the sequencer waits for a command.
// Reset: a clearing pass over all MAX_PAGES (1024) entries runs first with
// in_tready low; cfg writes are taken during it.
// Stall: the result sits in an output register; a new command is accepted
// while it waits, and the next result holds in the sequencer until
// out_tready frees the register.
// ----------------------------------------------------------------------------
`include "contiguous_page_allocator_macros.svh"

module contiguous_page_allocator (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [cpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cpa_pkg::ADDR_W-1:0]         cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [31:0] request_amount, [63:32] release_address
  input  logic [cpa_pkg::IN_DATA_W-1:0]      in_tdata,
  // [1:0] operation
  input  logic [cpa_pkg::IN_USER_W-1:0]      in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [31:0] granted_address, [33:32] status, [39:34] zero
  output logic [cpa_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import cpa_pkg::*;

  geom_t             geom;
  mem_req_t          mem_req;
  logic [1:0]        rd_data;
  result_t           res;
  logic              res_take;
  logic              out_valid_r;
  logic [ADDR_W-1:0] out_addr_r;
  status_t           out_status_r;

  cpa_geom u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .geom      (geom)
  );

  cpa_flag_store u_flags (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  cpa_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (op_t'(in_tuser[1:0])),
    .in_amount (in_tdata[AMT_W-1:0]),
    .in_addr   (in_tdata[AMT_W+ADDR_W-1:AMT_W]),
    .geom      (geom),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .res       (res),
    .res_take  (res_take)
  );

  assign res_take = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid && res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_take) begin
      out_addr_r   <= res.addr;
      out_status_r <= res.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-ADDR_W-STATUS_W){1'b0}}, out_status_r, out_addr_r};

  `CPA_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready after accept")
  `CPA_ASSERT_IMP(a_fail_null, out_valid_r && out_status_r == ST_FAIL, out_addr_r == '0, "fail addr")
  `CPA_ASSERT_IMP(a_ign_null, out_valid_r && out_status_r == ST_IGNORED, out_addr_r == '0, "ign addr")
  `CPA_ASSERT_IMP(a_no_write_idle, mem_req.we, !in_tready, "flag write while idle")

endmodule
